// File: design/cts_pkg.sv
package cts_pkg;

  localparam int MAX_TERMS = 32;
  localparam int K_W       = $clog2(MAX_TERMS);
  localparam int TC_W      = 6;
  localparam int ANG_W     = 18;
  localparam int OUT_W     = 32;
  localparam int MAG_W     = 40;
  localparam int T_W       = 48;
  localparam int SUM_W     = 48;
  localparam int XM_W      = 28;
  localparam int Q         = 24;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [ADDR_W-1:0] ADDR_TERM_COUNT = 3'd0;
  localparam logic [TC_W-1:0]   TERM_COUNT_RST  = 6'd10;
  localparam logic [TC_W-1:0]   N_MAX           = TC_W'(MAX_TERMS);

  // Degrees to radians: |a| * 1286144 / 1125 = |a| * 1143 + (|a| * 269 + 562) / 1125.
  localparam logic [31:0] CONV_INT   = 32'd1143;
  localparam logic [31:0] CONV_FRAC  = 32'd269;
  localparam logic [63:0] CONV_BIAS  = 64'd562;
  localparam int          DIV_SHIFT  = 26;
  localparam logic [31:0] DIV_RECIP  = 32'd59652;
  localparam logic [31:0] DIV_K      = 32'd1125;
  localparam logic [DIV_SHIFT-1:0] DIV_K_REM = DIV_SHIFT'(1125);

  localparam logic [63:0]      SQ_ROUND = 64'd1 << (Q - 1);
  localparam logic [MAG_W-1:0] MAG_ONE  = MAG_W'(1) << Q;

  // Reciprocal of (2k-1)(2k) in Q0.32, indexed by k. Entry zero is unused.
  localparam logic [31:0] RECIP_TAB [MAX_TERMS] = '{
    32'd0,          32'd2147483648, 32'd357913941,  32'd143165576,
    32'd76695844,   32'd47721858,   32'd32537631,   32'd23598721,
    32'd17895697,   32'd14035840,   32'd11302545,   32'd9296466,
    32'd7780737,    32'd6607641,    32'd5681173,    32'd4936744,
    32'd4329604,    32'd3827956,    32'd3408704,    32'd3054742,
    32'd2753184,    32'd2494173,    32'd2270067,    32'd2074863,
    32'd1903797,    32'd1753047,    32'd1619520,    32'd1500687,
    32'd1394469,    32'd1299143,    32'd1213267,    32'd1135633
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CV0,
    ST_CV1,
    ST_CV2,
    ST_CV3,
    ST_CV4,
    ST_SQ0,
    ST_SQ1,
    ST_T0,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_LAST,
    ST_SAT
  } state_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [63:0] c;
  } mul_req_t;

endpackage

// File: design/cts_cfg.sv
module cts_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cts_pkg::ADDR_W-1:0] paddr,
  input  logic [cts_pkg::DATA_W-1:0] pwdata,
  output logic [cts_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output logic [cts_pkg::TC_W-1:0]   term_count
);
  import cts_pkg::*;

  logic [TC_W-1:0] tc_r;
  logic [TC_W-1:0] tc_nxt;

  always_comb begin
    tc_nxt = tc_r;
    if (psel && penable && pwrite && (paddr == ADDR_TERM_COUNT)) begin
      tc_nxt = pwdata[TC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= TERM_COUNT_RST;
    end else begin
      tc_r <= tc_nxt;
    end
  end

  assign prdata     = (paddr == ADDR_TERM_COUNT) ? DATA_W'(tc_r) : '0;
  assign pready     = 1'b1;
  assign term_count = tc_r;

endmodule

// File: design/cts_mul.sv
module cts_mul (
  input  cts_pkg::mul_req_t req,
  output logic [63:0]       y
);
  import cts_pkg::*;

  logic [63:0] prod;

  assign prod = {32'd0, req.a} * {32'd0, req.b};
  assign y    = prod + req.c;

endmodule

// File: design/cts_core.sv
module cts_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [cts_pkg::ANG_W-1:0] angle,
  input  logic [cts_pkg::TC_W-1:0]         term_count,
  input  logic [63:0]                      mul_y,
  output cts_pkg::mul_req_t                mul_req,
  output logic                             busy,
  output logic                             out_valid,
  output logic signed [cts_pkg::OUT_W-1:0] out_value,
  output logic                             out_sat
);
  import cts_pkg::*;

  state_t                   state_r, state_nxt;
  logic [K_W-1:0]           k_r, k_nxt;
  logic                     valid_r, valid_nxt;
  logic [ANG_W-1:0]         ang_r, ang_nxt;
  logic [63:0]              p_r, p_nxt;
  logic [T_W-1:0]           t_r, t_nxt;
  logic [XM_W-1:0]          xm_r, xm_nxt;
  logic [31:0]              x2_r, x2_nxt;
  logic [MAG_W-1:0]         mag_r, mag_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [OUT_W-1:0]         val_r, val_nxt;
  logic                     sat_r, sat_nxt;

  logic [ANG_W-1:0]         amag;
  logic [TC_W-1:0]          n_eff;
  logic                     last_k;
  logic [DIV_SHIFT-1:0]     rem;
  logic signed [SUM_W-1:0]  smag;
  logic [SUM_W-OUT_W:0]     sum_hi;

  assign amag   = ang_r[ANG_W-1] ? (~ang_r + 1'b1) : ang_r;
  assign n_eff  = (term_count > N_MAX) ? N_MAX : term_count;
  assign last_k = ({1'b0, k_r} == (n_eff - 1'b1));
  assign rem    = t_r[DIV_SHIFT-1:0] - p_r[DIV_SHIFT-1:0];
  assign smag   = {{(SUM_W-MAG_W){1'b0}}, mag_r};
  assign sum_hi = sum_r[SUM_W-1:OUT_W-1];

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    valid_nxt = 1'b0;
    ang_nxt   = ang_r;
    p_nxt     = p_r;
    t_nxt     = t_r;
    xm_nxt    = xm_r;
    x2_nxt    = x2_r;
    mag_nxt   = mag_r;
    sum_nxt   = sum_r;
    val_nxt   = val_r;
    sat_nxt   = sat_r;
    mul_req   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          ang_nxt   = angle;
          state_nxt = ST_CV0;
        end
      end
      ST_CV0: begin
        mul_req.a = 32'(amag);
        mul_req.b = CONV_FRAC;
        mul_req.c = CONV_BIAS;
        t_nxt     = mul_y[T_W-1:0];
        state_nxt = ST_CV1;
      end
      ST_CV1: begin
        mul_req.a = t_r[31:0];
        mul_req.b = DIV_RECIP;
        p_nxt     = mul_y;
        state_nxt = ST_CV2;
      end
      ST_CV2: begin
        mul_req.a = p_r[DIV_SHIFT+31:DIV_SHIFT];
        mul_req.b = DIV_K;
        xm_nxt    = p_r[DIV_SHIFT+XM_W-1:DIV_SHIFT];
        p_nxt     = mul_y;
        state_nxt = ST_CV3;
      end
      ST_CV3: begin
        xm_nxt    = xm_r + XM_W'(rem >= DIV_K_REM);
        state_nxt = ST_CV4;
      end
      ST_CV4: begin
        mul_req.a = 32'(amag);
        mul_req.b = CONV_INT;
        mul_req.c = 64'(xm_r);
        xm_nxt    = mul_y[XM_W-1:0];
        state_nxt = ST_SQ0;
      end
      ST_SQ0: begin
        mul_req.a = 32'(xm_r);
        mul_req.b = 32'(xm_r);
        mul_req.c = SQ_ROUND;
        p_nxt     = mul_y;
        state_nxt = ST_SQ1;
      end
      ST_SQ1: begin
        x2_nxt  = p_r[Q+31:Q];
        mag_nxt = MAG_ONE;
        sum_nxt = '0;
        k_nxt   = '0;
        if (n_eff == '0) begin
          state_nxt = ST_SAT;
        end else if (n_eff == TC_W'(1)) begin
          state_nxt = ST_LAST;
        end else begin
          k_nxt     = K_W'(1);
          state_nxt = ST_T0;
        end
      end
      ST_T0: begin
        mul_req.a = 32'(mag_r[Q-1:0]);
        mul_req.b = x2_r;
        p_nxt     = mul_y;
        sum_nxt   = k_r[0] ? (sum_r + smag) : (sum_r - smag);
        state_nxt = ST_T1;
      end
      ST_T1: begin
        mul_req.a = 32'(mag_r[MAG_W-1:Q]);
        mul_req.b = x2_r;
        mul_req.c = 64'(p_r[63:Q]);
        t_nxt     = mul_y[T_W-1:0];
        state_nxt = ST_T2;
      end
      ST_T2: begin
        mul_req.a = t_r[31:0];
        mul_req.b = RECIP_TAB[k_r];
        p_nxt     = mul_y;
        state_nxt = ST_T3;
      end
      ST_T3: begin
        mul_req.a = 32'(t_r[T_W-1:32]);
        mul_req.b = RECIP_TAB[k_r];
        mul_req.c = 64'(p_r[63:32]);
        mag_nxt   = mul_y[MAG_W-1:0];
        if (last_k) begin
          state_nxt = ST_LAST;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_T0;
        end
      end
      ST_LAST: begin
        sum_nxt   = k_r[0] ? (sum_r - smag) : (sum_r + smag);
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        if ((&sum_hi) || !(|sum_hi)) begin
          val_nxt = sum_r[OUT_W-1:0];
          sat_nxt = 1'b0;
        end else begin
          val_nxt = sum_r[SUM_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
          sat_nxt = 1'b1;
        end
        valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ang_r <= ang_nxt;
    p_r   <= p_nxt;
    t_r   <= t_nxt;
    xm_r  <= xm_nxt;
    x2_r  <= x2_nxt;
    mag_r <= mag_nxt;
    sum_r <= sum_nxt;
    val_r <= val_nxt;
    sat_r <= sat_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = valid_r;
  assign out_value = val_r;
  assign out_sat   = sat_r;

endmodule

// File: design/cosine_taylor_series_top.sv
// Sequencing: with n = min(term_count, 32), a start taken while idle converts the angle,
// squares it, sums n series terms and saturates; busy stays high until the result strobe.
// One transaction at a time; the single shared 32x32 multiplier takes four passes per
// series term after the first.
// Reset (rst_n, synchronous, active low) clears the sequencer and sets term_count to 10.
// The receiver cannot stall: each result is shown for exactly one cycle on out_valid.
module cosine_taylor_series_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [cts_pkg::ANG_W-1:0] in_angle_degrees,
  output logic                             out_valid,
  output logic signed [cts_pkg::OUT_W-1:0] out_cosine_value,
  output logic                             out_saturated,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cts_pkg::ADDR_W-1:0]       paddr,
  input  logic [cts_pkg::DATA_W-1:0]       pwdata,
  output logic [cts_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);
  import cts_pkg::*;

  logic [TC_W-1:0] term_count;
  mul_req_t        mul_req;
  logic [63:0]     mul_y;

  cts_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .term_count (term_count)
  );

  cts_mul u_mul (
    .req (mul_req),
    .y   (mul_y)
  );

  cts_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .angle      (in_angle_degrees),
    .term_count (term_count),
    .mul_y      (mul_y),
    .mul_req    (mul_req),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_value  (out_cosine_value),
    .out_sat    (out_saturated)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("result strobe without preceding work");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_cosine_value == 32'sh7FFFFFFF || out_cosine_value == 32'sh80000000))
    else $error("saturated result is not a range end");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

// File: bench/cosine_result_check.sv
module cosine_result_check (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic signed [cts_pkg::ANG_W-1:0]  in_angle_degrees,
  input  logic                              out_valid,
  input  logic signed [cts_pkg::OUT_W-1:0]  out_cosine_value,
  input  logic                              out_saturated,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cts_pkg::ADDR_W-1:0]        paddr,
  input  logic [cts_pkg::DATA_W-1:0]        pwdata,
  input  logic [cts_pkg::DATA_W-1:0]        prdata,
  input  logic                              pready,
  output int                                fail_count,
  output int                                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import cts_pkg::*;

  typedef struct {
    logic signed [OUT_W-1:0] cosine_value;
    logic                    saturated;
  } cosine_expect_t;

  cosine_expect_t    cosine_expect_q[$];
  logic [TC_W-1:0]   term_count_model = TERM_COUNT_RST;
  int                errors = 0;
  int                backlog = 0;

  assign fail_count  = errors;
  assign outstanding = backlog;

  function automatic logic [63:0] fixed_mul(input logic [63:0] a, input logic [63:0] b,
                                            input int frac_bits);
    logic [63:0] low_mask;
    low_mask = (64'd1 << frac_bits) - 64'd1;
    return (a >> frac_bits) * b + (((a & low_mask) * b) >> frac_bits);
  endfunction

  function automatic cosine_expect_t predict_cosine(input logic [ANG_W-1:0] angle,
                                                    input logic [TC_W-1:0] terms);
    logic [63:0]    angle_mag;
    logic [63:0]    rad_mag;
    logic [63:0]    rad_sq;
    logic [63:0]    term_mag;
    logic [63:0]    inv_denom;
    longint         series_sum;
    int             n_terms;
    cosine_expect_t res;
    angle_mag = angle[ANG_W-1] ? (64'h40000 - 64'(angle)) : 64'(angle);
    rad_mag   = (angle_mag * 64'd1286144 + 64'd562) / 64'd1125;
    rad_sq    = (rad_mag * rad_mag + (64'd1 << 23)) >> 24;
    n_terms   = (int'(terms) > MAX_TERMS) ? MAX_TERMS : int'(terms);
    term_mag  = 64'd1 << 24;
    series_sum = 0;
    for (int k = 0; k < n_terms; k++) begin
      if (k > 0) begin
        inv_denom = (64'd1 << 32) / (64'(2 * k - 1) * 64'(2 * k));
        term_mag  = fixed_mul(fixed_mul(term_mag, rad_sq, 24), inv_denom, 32);
      end
      if (k % 2 == 1) begin
        series_sum = series_sum - longint'(term_mag);
      end else begin
        series_sum = series_sum + longint'(term_mag);
      end
    end
    if (series_sum > 64'sd2147483647) begin
      res.cosine_value = 32'h7FFF_FFFF;
      res.saturated    = 1'b1;
    end else if (series_sum < -64'sd2147483648) begin
      res.cosine_value = 32'h8000_0000;
      res.saturated    = 1'b1;
    end else begin
      res.cosine_value = series_sum[OUT_W-1:0];
      res.saturated    = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    cosine_expect_t want;
    if (!rst_n) begin
      term_count_model = TERM_COUNT_RST;
      cosine_expect_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == ADDR_TERM_COUNT) begin
            term_count_model = pwdata[TC_W-1:0];
          end
        end else if (paddr == ADDR_TERM_COUNT && prdata !== DATA_W'(term_count_model)) begin
          $error("term_count readback: expected %0d, got %0d", term_count_model, prdata);
          errors++;
        end
      end
      if (start && !busy) begin
        cosine_expect_q.push_back(predict_cosine(in_angle_degrees, term_count_model));
      end
      if (out_valid) begin
        if (cosine_expect_q.size() == 0) begin
          $error("unexpected result: cosine_value %0d, saturated %0b",
                 out_cosine_value, out_saturated);
          errors++;
        end else begin
          want = cosine_expect_q.pop_front();
          if (out_cosine_value !== want.cosine_value) begin
            $error("cosine_value mismatch: expected %0d, got %0d",
                   want.cosine_value, out_cosine_value);
            errors++;
          end
          if (out_saturated !== want.saturated) begin
            $error("saturated mismatch: expected %0b, got %0b",
                   want.saturated, out_saturated);
            errors++;
          end
        end
      end
    end
    backlog <= cosine_expect_q.size();
  end

endmodule

// File: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cts_pkg::*;

  localparam int                WATCHDOG_LIMIT = 2000;
  localparam int                DRAIN_CYCLES   = 4 * MAX_TERMS + 20;
  localparam int                RANDOM_ITEMS   = 1230;
  localparam logic [ADDR_W-1:0] ADDR_UNMAPPED  = 3'd4;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [ANG_W-1:0]   in_angle_degrees = '0;
  logic                      out_valid;
  logic signed [OUT_W-1:0]   out_cosine_value;
  logic                      out_saturated;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [DATA_W-1:0]         pwdata = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  int                        fail_count;
  int                        outstanding;
  int                        idle_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  cosine_taylor_series_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_angle_degrees (in_angle_degrees),
    .out_valid        (out_valid),
    .out_cosine_value (out_cosine_value),
    .out_saturated    (out_saturated),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  cosine_result_check u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_angle_degrees (in_angle_degrees),
    .out_valid        (out_valid),
    .out_cosine_value (out_cosine_value),
    .out_saturated    (out_saturated),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap(input bit no_idle);
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 4);
    if (roll < 97) return $urandom_range(5, 140);
    return $urandom_range(141, 300);
  endfunction

  function automatic logic [ANG_W-1:0] pick_angle();
    int roll;
    int deg;
    roll = $urandom_range(0, 99);
    if (roll < 70) return ANG_W'(int'($urandom_range(0, 184320)) - 92160);
    if (roll < 85) return ANG_W'($urandom);
    deg = int'($urandom_range(0, 8)) * 90 - 360;
    return ANG_W'(deg * 256 + int'($urandom_range(0, 6)) - 3);
  endfunction

  task automatic send_angle(input logic [ANG_W-1:0] angle, input int gap);
    start            <= 1'b1;
    in_angle_degrees <= angle;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  task automatic apb_access(input logic is_write, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_terms(input logic [TC_W-1:0] terms);
    logic [DATA_W-1:0] data;
    wait_drained();
    data           = $urandom;
    data[TC_W-1:0] = terms;
    apb_access(1'b1, ADDR_TERM_COUNT, data);
    if ($urandom_range(0, 2) == 0) begin
      apb_access(1'b1, ADDR_UNMAPPED, $urandom);
    end
    apb_access(1'b0, ADDR_TERM_COUNT, '0);
  endtask

  initial begin
    logic signed [ANG_W-1:0] corner_angles [13];
    int phase_terms [13];
    int per_phase;
    bit no_idle;
    corner_angles = '{
      0, 1, -1, 256, -256, 23040, -23040, 46080, -46080, 92160, -92160, 131071, -131072
    };
    phase_terms = '{5, 0, 32, 63, 1, 2, 10, 20, 33, 3, 12, 31, 7};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset value of term_count first, then the zero, full, oversized and single-term counts.
    foreach (corner_angles[i]) send_angle(corner_angles[i], pick_gap(1'b0));
    set_terms(6'd0);
    send_angle(18'sd0, 0);
    send_angle(-18'sd131072, 0);
    set_terms(6'd32);
    send_angle(18'sd131071, pick_gap(1'b0));
    send_angle(-18'sd131072, pick_gap(1'b0));
    send_angle(18'sd92160, pick_gap(1'b0));
    set_terms(6'd63);
    send_angle(18'sd131071, 0);
    set_terms(6'd1);
    apb_access(1'b1, ADDR_UNMAPPED, $urandom);
    send_angle(-18'sd92160, 0);

    per_phase = RANDOM_ITEMS / $size(phase_terms);
    foreach (phase_terms[p]) begin
      set_terms(TC_W'(phase_terms[p]));
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < per_phase; i++) begin
        send_angle(pick_angle(), pick_gap(no_idle));
        if ($urandom_range(0, 79) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
design/cts_pkg.sv
design/cts_cfg.sv
design/cts_mul.sv
design/cts_core.sv
design/cosine_taylor_series_top.sv
bench/cosine_result_check.sv
bench/tb.sv
